// ----- sv/tcs_pkg.sv -----
// Package for the text console with scrollback: sizes, action codes, types.
// No dependencies; used by tcs_ctrl, tcs_dp and the top level.
package tcs_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 128;
    localparam int HistRows = 256;
    localparam int RowW = $clog2(MaxRows);
    localparam int ColW = $clog2(MaxCols);
    localparam int HistW = $clog2(HistRows);
    localparam int ScrDepth = MaxRows * MaxCols;
    localparam int HisDepth = HistRows * MaxCols;
    localparam int ScrAw = $clog2(ScrDepth);
    localparam int HisAw = $clog2(HisDepth);
    localparam logic [7:0] NewlineCode = 8'd10;
    localparam logic [7:0] BlankCode = 8'd32;

    localparam logic [2:0] ActWrite = 3'd0;
    localparam logic [2:0] ActSetCur = 3'd1;
    localparam logic [2:0] ActClear = 3'd2;
    localparam logic [2:0] ActPgUp = 3'd3;
    localparam logic [2:0] ActPgDn = 3'd4;
    localparam logic [2:0] ActBottom = 3'd5;
    localparam logic [2:0] ActRead = 3'd6;
    localparam logic [2:0] ActNop = 3'd7;

    localparam logic CfgRows = 1'b0;
    localparam logic CfgCols = 1'b1;

    // Controller commands to the datapath
    typedef struct packed {
        logic       take;      // latch the request
        logic       exec;      // run the simple actions and the byte write decision
        logic       clr_step;  // blank one screen cell (clearing pass)
        logic       clr_start;
        logic       scr_rd;    // issue scroll read of current cell
        logic       scr_wr;    // write the read cell to history and row above
        logic       scr_adv;   // advance scroll cursor
        logic       scr_done;  // finish scroll, then store pending byte
        logic       rd_issue;  // issue a view read
        logic       rd_take;   // capture view read data
        logic       out_load;  // load output register
    } t_cmd;

    // Datapath status for the controller
    typedef struct packed {
        logic need_scroll;
        logic clr_last;
        logic scr_last;
        logic is_read;
        logic is_clear;
    } t_stat;
endpackage

// ----- sv/tcs_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module tcs_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/tcs_ctrl.sv -----
// Controller state machine for the text console.
// Depends on tcs_pkg.
module tcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tcs_pkg::t_stat i_st,
    output tcs_pkg::t_cmd  o_cmd
);
    import tcs_pkg::*;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EXEC  = 9'b000000100,
        S_SRD   = 9'b000001000,
        S_SWR   = 9'b000010000,
        S_SDONE = 9'b000100000,
        S_RD    = 9'b001000000,
        S_RDT   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    // Decode state into commands and next state
    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = i_st.is_clear ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    o_cmd.take = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_st.is_clear) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else if (i_st.is_read) begin
                    n_state = S_RD;
                end else if (i_st.need_scroll) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SRD: begin
                o_cmd.scr_rd = 1'b1;
                n_state = S_SWR;
            end
            S_SWR: begin
                o_cmd.scr_wr = 1'b1;
                o_cmd.scr_adv = 1'b1;
                n_state = i_st.scr_last ? S_SDONE : S_SRD;
            end
            S_SDONE: begin
                o_cmd.scr_done = 1'b1;
                n_state = S_OUT;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RDT;
            end
            S_RDT: begin
                o_cmd.rd_take = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!(r_ovalid && i_stall)) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ----- sv/tcs_dp.sv -----
// Datapath of the text console: screen and history RAMs, cursor, view, outputs.
// Depends on tcs_pkg and tcs_ram.
module tcs_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  logic [2:0]    i_action,
    input  logic [7:0]    i_char_code,
    input  logic [6:0]    i_col,
    input  logic [5:0]    i_row,
    input  tcs_pkg::t_cmd  i_cmd,
    output tcs_pkg::t_stat o_st,
    output logic [7:0]    o_cell_char,
    output logic [7:0]    o_cursor_col,
    output logic [5:0]    o_cursor_row,
    output logic [8:0]    o_view_offset,
    output logic [8:0]    o_history_rows
);
    import tcs_pkg::*;

    logic [6:0] r_rows_cfg;
    logic [7:0] r_cols_cfg;
    logic [RowW:0] rows;
    logic [ColW:0] cols;
    logic [2:0] r_act;
    logic [7:0] r_ch;
    logic [6:0] r_c;
    logic [5:0] r_r;
    logic [8:0] r_cur_col, n_cur_col;
    logic [RowW-1:0] r_cur_row, n_cur_row;
    logic [HistW-1:0] r_head;
    logic [HistW:0] r_count;
    logic [HistW:0] r_shift;
    logic r_pend;      // byte to store after scroll
    logic r_hpass;     // scroll walk is copying the top row to history
    logic [ScrAw-1:0] r_ca;  // clear address
    logic [RowW-1:0] r_sr;   // scroll row
    logic [ColW-1:0] r_sc;   // scroll col
    logic r_vsel;      // view cell comes from the screen
    logic r_vdirect;   // view cell is the screen cell at the same row
    logic r_vzero;
    logic r_vblank;
    logic [7:0] r_cell;
    logic [HistW-1:0] slot_push;
    logic [RowW:0] page;

    // Saturate register values into the usable range
    always_comb begin
        if (r_rows_cfg == '0) rows = (RowW+1)'(1);
        else if ({1'b0, r_rows_cfg} > 8'(MaxRows)) rows = (RowW+1)'(MaxRows);
        else rows = (RowW+1)'(r_rows_cfg);
        if (r_cols_cfg == '0) cols = (ColW+1)'(1);
        else if ({1'b0, r_cols_cfg} > 9'(MaxCols)) cols = (ColW+1)'(MaxCols);
        else cols = (ColW+1)'(r_cols_cfg);
    end
    assign page = rows - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 7'd30;
            r_cols_cfg <= 8'd80;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgRows) r_rows_cfg <= i_cfg_data[6:0];
            else r_cols_cfg <= i_cfg_data;
        end
    end

    // Byte write decision
    logic nl, wrap, adv_line, last_row;
    assign nl = (r_act == ActWrite) && (r_ch == NewlineCode);
    assign wrap = (r_act == ActWrite) && (r_cur_col >= 9'(cols));
    assign adv_line = nl || wrap;
    assign last_row = ({1'b0, r_cur_row} + 1'b1) >= rows;

    assign o_st.need_scroll = adv_line && last_row;
    assign o_st.is_read = (r_act == ActRead);
    assign o_st.is_clear = (r_act == ActClear);
    assign o_st.clr_last = (r_ca == ScrAw'(ScrDepth - 1));
    assign o_st.scr_last = !r_hpass && (r_sc == ColW'(cols - 1'b1)) &&
                           ({1'b0, r_sr} + 1'b1 >= rows);

    // Screen and history RAM ports
    logic scr_we;
    logic [ScrAw-1:0] scr_wa, scr_ra;
    logic [7:0] scr_wd, scr_rd;
    logic his_we;
    logic [HisAw-1:0] his_wa, his_ra;
    logic [7:0] his_rd;
    logic [RowW-1:0] vrow;
    logic [HistW:0] hidx;
    logic [HistW-1:0] hslot;
    logic store_now;
    logic [RowW-1:0] st_row;
    logic [8:0] st_col;

    assign slot_push = r_head + r_count[HistW-1:0];
    // Store position after the line decision
    assign st_row = adv_line ? (last_row ? RowW'(rows - 1'b1) : r_cur_row + 1'b1) : r_cur_row;
    assign st_col = wrap ? 9'd0 : r_cur_col;
    assign store_now = (r_act == ActWrite) && !nl && ({1'b0, st_row} < rows) &&
                       (st_col < 9'(cols));

    // View read address composition
    assign hidx = r_count + (HistW+1)'(r_r) - r_shift;
    assign hslot = r_head + hidx[HistW-1:0];
    assign vrow = RowW'((RowW+1)'(r_r) - r_shift[RowW:0]);

    always_comb begin
        scr_we = 1'b0;
        scr_wa = '0;
        scr_wd = BlankCode;
        scr_ra = {r_sr, r_sc} + ScrAw'(MaxCols);
        his_we = 1'b0;
        his_wa = {slot_push, r_sc};
        his_ra = {hslot, r_c};
        if (i_cmd.clr_step) begin
            scr_we = 1'b1;
            scr_wa = r_ca;
        end else if (i_cmd.exec && store_now && !o_st.need_scroll) begin
            scr_we = 1'b1;
            scr_wa = {st_row, st_col[ColW-1:0]};
            scr_wd = r_ch;
        end else if (i_cmd.scr_done && r_pend) begin
            scr_we = 1'b1;
            scr_wa = {RowW'(rows - 1'b1), ColW'(0)};
            scr_wd = r_ch;
        end else if (i_cmd.scr_wr && !r_hpass) begin
            scr_we = 1'b1;
            scr_wa = {r_sr, r_sc};
            scr_wd = ({1'b0, r_sr} + 1'b1 >= rows) ? BlankCode : scr_rd;
        end
        if (i_cmd.scr_rd && r_hpass) begin
            scr_ra = {r_sr, r_sc};
        end else if (i_cmd.rd_issue) begin
            scr_ra = {r_vdirect ? r_r[RowW-1:0] : vrow, r_c};
        end
        // First scroll row: history gets the top row read in the same pass
        his_we = i_cmd.scr_wr && r_sr == '0;
    end

    // Row 0 is visited twice: once read to history, then row one moves up into it.
    // Scroll state: pass 0 reads row0 for history, normal pass does row shift.
    logic [7:0] his_wd;
    assign his_wd = ({1'b0, r_sc} < cols) ? scr_rd : BlankCode;

    tcs_ram #(.Width(8), .Depth(ScrDepth)) u_scr (
        .i_clk(i_clk), .i_we(scr_we), .i_waddr(scr_wa), .i_wdata(scr_wd),
        .i_raddr(scr_ra), .o_rdata(scr_rd)
    );
    tcs_ram #(.Width(8), .Depth(HisDepth)) u_his (
        .i_clk(i_clk), .i_we(his_we && r_hpass), .i_waddr(his_wa), .i_wdata(his_wd),
        .i_raddr(his_ra), .o_rdata(his_rd)
    );

    // Sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_head <= '0;
            r_count <= '0;
            r_shift <= '0;
            r_pend <= 1'b0;
            r_act <= ActNop;
            r_sr <= '0;
            r_sc <= '0;
            r_hpass <= 1'b1;
        end else begin
            if (i_cmd.take) begin
                r_act <= i_action;
                r_ch <= i_char_code;
                r_c <= i_col;
                r_r <= i_row;
            end
            if (i_cmd.clr_step) begin
                r_ca <= r_ca + 1'b1;
            end
            if (i_cmd.clr_start) begin
                r_ca <= '0;
            end
            if (i_cmd.exec) begin
                r_sr <= '0;
                r_sc <= '0;
                r_hpass <= 1'b1;
                r_pend <= (r_act == ActWrite) && !nl;
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                case (r_act)
                    ActClear: begin
                        r_head <= '0;
                        r_count <= '0;
                        r_shift <= '0;
                    end
                    ActPgUp: if (page != 0) begin
                        if (r_shift + (HistW+1)'(page) > r_count) r_shift <= r_count;
                        else r_shift <= r_shift + (HistW+1)'(page);
                    end
                    ActPgDn: if (page != 0) begin
                        r_shift <= (r_shift > (HistW+1)'(page)) ?
                                   r_shift - (HistW+1)'(page) : '0;
                    end
                    ActBottom: r_shift <= '0;
                    default: ;
                endcase
                r_vzero <= ({1'b0, r_r} >= rows) || ({1'b0, r_c} >= 8'(cols));
                r_vdirect <= (r_shift == '0) || ({1'b0, r_r} == 7'(rows - 1'b1));
                r_vsel <= (r_shift == '0) || ({1'b0, r_r} == 7'(rows - 1'b1)) ||
                          ((HistW+1)'(r_r) >= r_shift);
                r_vblank <= (r_count + (HistW+1)'(r_r)) < r_shift;
            end
            // Scroll walk: history copy of row 0, then shift rows up
            if (i_cmd.scr_adv) begin
                if (r_hpass) begin
                    if (r_sc == ColW'(MaxCols - 1)) begin
                        r_sc <= '0;
                        r_hpass <= 1'b0;
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end else if (r_sc == ColW'(cols - 1'b1)) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            if (i_cmd.scr_done) begin
                if (r_count >= (HistW+1)'(HistRows)) r_head <= r_head + 1'b1;
                else r_count <= r_count + 1'b1;
            end
        end
    end

    // Cursor update
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        case (r_act)
            ActWrite: begin
                if (nl) begin
                    n_cur_col = '0;
                    n_cur_row = st_row;
                end else begin
                    n_cur_col = st_col + 1'b1;
                    n_cur_row = st_row;
                end
            end
            ActSetCur: begin
                n_cur_col = ({1'b0, r_c} < 8'(cols)) ? 9'(r_c) : '0;
                n_cur_row = ({1'b0, r_r} < rows) ? RowW'(r_r) : '0;
            end
            ActClear: begin
                n_cur_col = '0;
                n_cur_row = '0;
            end
            default: ;
        endcase
    end

    // Capture view cell, cleared when a request executes
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_take) begin
            if (r_vzero) r_cell <= 8'd0;
            else if (r_vsel) r_cell <= scr_rd;
            else if (r_vblank) r_cell <= BlankCode;
            else r_cell <= his_rd;
        end else if (i_cmd.exec) begin
            r_cell <= 8'd0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_char <= r_cell;
            o_cursor_col <= r_cur_col[7:0];
            o_cursor_row <= 6'(r_cur_row);
            o_view_offset <= 9'(r_shift);
            o_history_rows <= 9'(r_count);
        end
    end
endmodule

// ----- sv/text_console_with_scrollback.sv -----
// Text console with scrollback: top level joining controller and datapath.
// A request is taken in idle, executed, then registered at the output;
// a view read adds an issue and a capture step, a scroll copies the top row
// to history and shifts the visible cells up, a clear blanks the screen RAM.
// Requests are handled one at a time. Reset: synchronous active low;
// afterwards a pass blanks the screen RAM before the first request is taken.
module text_console_with_scrollback (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_action,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_col,
    input  logic [5:0] i_row,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cursor_col,
    output logic [5:0] o_cursor_row,
    output logic [8:0] o_view_offset,
    output logic [8:0] o_history_rows
);
    import tcs_pkg::*;

    t_cmd  cmd;
    t_stat st;

    tcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_st(st), .o_cmd(cmd)
    );

    tcs_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_action(i_action), .i_char_code(i_char_code),
        .i_col(i_col), .i_row(i_row), .i_cmd(cmd), .o_st(st),
        .o_cell_char(o_cell_char), .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row), .o_view_offset(o_view_offset),
        .o_history_rows(o_history_rows)
    );

    // Offset never exceeds history count on a delivered result
    a_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_view_offset <= o_history_rows) else $error("view beyond history");
    // No request taken while a result would be overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall) else $error("input taken during stall");
    // History count bounded
    a_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_history_rows <= 9'd256) else $error("history overflow");
endmodule
